/* design/ffra_pkg.sv */
// Shared types and constants for the first-fit range allocator.
package ffra_pkg;

  localparam int DefMaxBlocks = 64;
  localparam int DefAddrBits  = 32;
  localparam int MaxAlignLog2 = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  localparam logic CFG_POOL_SIZE = 1'b0;
  localparam logic CFG_ALIGN     = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic [31:0] granted_size;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_WAIT,
    S_EVAL,
    S_SHIFT_RD,
    S_SHIFT_WAIT,
    S_SHIFT_WR,
    S_PLACE,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr_idx;
    logic rd;
    logic adv;
    logic set_k_top;
    logic set_k_idx;
    logic shift_rd;
    logic shift_wr;
    logic k_step;
    logic place;
    logic [1:0] res_status;
    logic res_grant;
    logic res_emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic too_big;
    logic full;
    logic at_end;
    logic hit;
    logic shift_done;
  } sts_t;

endpackage

/* design/ffra_ctrl.sv */
// Controller state machine of the first-fit range allocator.
module ffra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ffra_pkg::sts_t sts,
  output ffra_pkg::cmd_t cmd
);
  import ffra_pkg::*;

  state_t state, state_next;
  logic   is_free_op;
  logic   is_free_op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      is_free_op <= 1'b0;
    end else begin
      state      <= state_next;
      is_free_op <= is_free_op_next;
    end
  end

  always_comb begin
    state_next      = state;
    is_free_op_next = is_free_op;
    cmd             = '0;
    busy            = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        is_free_op_next = sts.is_free;
        cmd.clr_idx     = 1'b1;
        if (!sts.is_free && sts.too_big) begin
          cmd.res_status = ST_NOFIT;
          cmd.res_emit   = 1'b1;
          state_next     = S_DONE;
        end else if (!sts.is_free && sts.full) begin
          cmd.res_status = ST_FULL;
          cmd.res_emit   = 1'b1;
          state_next     = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = S_EVAL;
      S_EVAL: begin
        if (sts.hit) begin
          if (is_free_op) begin
            cmd.set_k_idx = 1'b1;
          end else begin
            cmd.set_k_top = 1'b1;
          end
          state_next = S_SHIFT_RD;
        end else if (sts.at_end) begin
          cmd.res_status = is_free_op ? ST_NOTFOUND : ST_NOFIT;
          cmd.res_emit   = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.shift_done) begin
          state_next = S_PLACE;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHIFT_WAIT;
        end
      end
      S_SHIFT_WAIT: state_next = S_SHIFT_WR;
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.k_step   = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_PLACE: begin
        cmd.place      = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_grant  = !is_free_op;
        cmd.res_emit   = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* design/ffra_dp.sv */
// Datapath of the first-fit range allocator: block table, gap scan, shifter.
module ffra_dp #(
  parameter int MAX_BLOCKS = ffra_pkg::DefMaxBlocks,
  parameter int ADDR_BITS  = ffra_pkg::DefAddrBits
) (
  input  logic           clk,
  input  logic           rst,
  input  ffra_pkg::req_t req,
  input  logic [31:0]    pool_size,
  input  logic [4:0]     alignment_log2,
  input  ffra_pkg::cmd_t cmd,
  output ffra_pkg::sts_t sts,
  output logic           done,
  output ffra_pkg::rsp_t result
);
  import ffra_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int VW = ADDR_BITS + 1;
  localparam int MW = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  logic [ADDR_BITS-1:0] mem_start [MAX_BLOCKS];
  logic [ADDR_BITS-1:0] mem_len   [MAX_BLOCKS];

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] k;
  logic          op_free;
  logic [VW-1:0] aligned;
  logic [VW-1:0] pool;
  logic [VW-1:0] prev_end;
  logic [MW-1:0] free_addr;
  logic [ADDR_BITS-1:0] rd_start, rd_len;
  logic          shrink;

  logic [4:0]    lg;
  logic [33:0]   gran_m1;
  logic [33:0]   rounded;
  logic [VW-1:0] addr_max;
  logic [VW-1:0] gap_end, gap;
  logic          entry_valid;

  assign lg       = (alignment_log2 > 5'(MaxAlignLog2)) ? 5'(MaxAlignLog2) : alignment_log2;
  assign gran_m1  = (34'd1 << lg) - 34'd1;
  assign rounded  = ({2'b00, req.request_size} + gran_m1) & ~gran_m1;
  assign addr_max = {1'b0, {ADDR_BITS{1'b1}}};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_free   <= req.action;
      free_addr <= MW'(req.block_address);
      if (VW >= 34) begin
        aligned <= VW'(rounded);
      end else begin
        aligned <= (rounded > 34'(addr_max)) ? {VW{1'b1}} : VW'(rounded);
      end
      pool <= (MW'(pool_size) > MW'(addr_max)) ? addr_max : VW'(pool_size);
    end
  end

  assign entry_valid = (idx < count);
  assign gap_end = entry_valid ? {1'b0, rd_start} : pool;
  assign gap     = (gap_end > prev_end) ? gap_end - prev_end : '0;

  assign sts.is_free    = op_free;
  assign sts.too_big    = aligned > pool;
  assign sts.full       = (count >= CW'(MAX_BLOCKS));
  assign sts.at_end     = op_free ? (idx + CW'(1) >= count) : !entry_valid;
  assign sts.hit        = op_free ? (entry_valid && MW'(rd_start) == free_addr)
                                  : (gap >= aligned);
  assign sts.shift_done = shrink ? (k + CW'(1) >= count) : (k == idx);

  always_ff @(posedge clk) begin
    if (cmd.rd && idx < count) begin
      rd_start <= mem_start[idx[IW-1:0]];
      rd_len   <= mem_len[idx[IW-1:0]];
    end else if (cmd.shift_rd) begin
      rd_start <= mem_start[shrink ? IW'(k + CW'(1)) : IW'(k - CW'(1))];
      rd_len   <= mem_len[shrink ? IW'(k + CW'(1)) : IW'(k - CW'(1))];
    end
    if (cmd.shift_wr) begin
      mem_start[k[IW-1:0]] <= rd_start;
      mem_len[k[IW-1:0]]   <= rd_len;
    end else if (cmd.place && !shrink) begin
      mem_start[idx[IW-1:0]] <= prev_end[ADDR_BITS-1:0];
      mem_len[idx[IW-1:0]]   <= aligned[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      k          <= '0;
      shrink     <= 1'b0;
      prev_end   <= '0;
      done       <= 1'b0;
      result     <= '0;
    end else begin
      done       <= cmd.res_emit;
      if (cmd.clr_idx) begin
        idx      <= '0;
        prev_end <= '0;
      end
      if (cmd.adv) begin
        idx <= idx + CW'(1);
        if (entry_valid) begin
          prev_end <= {1'b0, rd_start} + {1'b0, rd_len};
        end
      end
      if (cmd.set_k_top) begin
        k      <= count;
        shrink <= 1'b0;
      end
      if (cmd.set_k_idx) begin
        k      <= idx;
        shrink <= 1'b1;
      end
      if (cmd.k_step) begin
        k <= shrink ? k + CW'(1) : k - CW'(1);
      end
      if (cmd.place) begin
        count <= shrink ? count - CW'(1) : count + CW'(1);
      end
      if (cmd.res_emit) begin
        result.status          <= cmd.res_status;
        result.granted_address <= cmd.res_grant ? 32'(prev_end) : 32'd0;
        result.granted_size    <= cmd.res_grant ? 32'(aligned) : 32'd0;
      end
    end
  end

endmodule

/* design/first_fit_range_allocator.sv */
// Top level of the first-fit range allocator.
//
// Usage: pulse start with an item on req while busy is low. action 0
// allocates request_size bytes (rounded up to 2^alignment_log2, capped at
// 2^16) at the first gap that fits in the sorted block table; action 1
// frees the block starting at block_address. One result per item appears
// on rsp for one cycle, marked by done; the receiver cannot stall.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 pool_size, 1
// alignment_log2; write only while busy is low. cfg_ready is always high.
// An allocation is first checked for size and a full table; then the table
// slots are scanned in order (one read port with registered data: read,
// wait and evaluate per slot); on a hit the entries moved by insert or
// remove are shifted (read, wait, write each) before placement. A rejection
// on size or full table ends after the check; a scan that finds nothing
// ends with no shift. Slots examined plus entries moved never exceed 64
// with 64 blocks. busy drops the cycle after done; no new item is accepted while busy is high.
// Reset clears the table count, pool_size to 0, alignment_log2 to 8.
module first_fit_range_allocator #(
  parameter int MAX_BLOCKS = ffra_pkg::DefMaxBlocks,
  parameter int ADDR_BITS  = ffra_pkg::DefAddrBits
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ffra_pkg::req_t req,
  output logic           done,
  output ffra_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [0:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import ffra_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] pool_size;
  logic [4:0]  alignment_log2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size      <= '0;
      alignment_log2 <= 5'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POOL_SIZE: pool_size      <= cfg_data;
        CFG_ALIGN:     alignment_log2 <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  ffra_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  ffra_dp #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .pool_size     (pool_size),
    .alignment_log2(alignment_log2),
    .cmd           (cmd),
    .sts           (sts),
    .done          (done),
    .result        (rsp)
  );

endmodule

/* design/ffra_checker.sv */
// Port-level checks for the first-fit range allocator.
module ffra_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input ffra_pkg::rsp_t rsp
);
  import ffra_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result outside a busy item");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("two results for one item");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.granted_address == '0 && rsp.granted_size == '0)
    else $error("failed item carries a grant");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);

/* tb/sv/tb_top.sv */
// Testbench for the first-fit range allocator: random and directed items checked by a scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import ffra_pkg::*;

  localparam int NumBlocks = 64;

  class alloc_scoreboard;
    logic [31:0] pool;
    logic [4:0]  align_lg;
    logic [31:0] starts[$];
    logic [31:0] lens[$];
    rsp_t        pending[$];
    int          errors;

    function new();
      pool = 0;
      align_lg = 5'd8;
      errors = 0;
    endfunction

    function void note_item(req_t r);
      rsp_t        e;
      int          lg;
      logic [32:0] gran;
      logic [32:0] aligned;
      logic [32:0] prev_end;
      logic [32:0] gap_end;
      logic [32:0] gap;
      bit          placed;
      e = '0;
      if (r.action == ACT_FREE) begin
        e.status = ST_NOTFOUND;
        for (int i = 0; i < starts.size(); i++) begin
          if (starts[i] == r.block_address) begin
            starts.delete(i);
            lens.delete(i);
            e.status = ST_OK;
            break;
          end
        end
      end else begin
        lg = (align_lg > MaxAlignLog2) ? MaxAlignLog2 : align_lg;
        gran = 33'd1 << lg;
        aligned = ({1'b0, r.request_size} + gran - 33'd1) & ~(gran - 33'd1);
        if (aligned > {1'b0, pool}) begin
          e.status = ST_NOFIT;
        end else if (starts.size() >= NumBlocks) begin
          e.status = ST_FULL;
        end else begin
          prev_end = 0;
          placed = 0;
          e.status = ST_NOFIT;
          for (int i = 0; i <= starts.size(); i++) begin
            gap_end = (i < starts.size()) ? {1'b0, starts[i]} : {1'b0, pool};
            gap = (gap_end > prev_end) ? gap_end - prev_end : 33'd0;
            if (gap >= aligned) begin
              starts.insert(i, prev_end[31:0]);
              lens.insert(i, aligned[31:0]);
              e.status = ST_OK;
              e.granted_address = prev_end[31:0];
              e.granted_size = aligned[31:0];
              break;
            end
            if (i < starts.size()) prev_end = {1'b0, starts[i]} + {1'b0, lens[i]};
          end
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", a);
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status || a.granted_address !== e.granted_address ||
          a.granted_size !== e.granted_size) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d addr=%h size=%h act st=%0d addr=%h size=%h",
                   e.status, e.granted_address, e.granted_size,
                   a.status, a.granted_address, a.granted_size);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;

  alloc_scoreboard sb;
  int idle_pct;
  logic [31:0] live_addrs[$];

  first_fit_range_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(rsp);
  end

  task automatic send_item(input req_t r);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(r);
    if (r.action == ACT_ALLOC) begin
      // addresses come back through results; track requested frees at random instead
    end
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic alloc(input logic [31:0] sz);
    req_t r;
    r = '0;
    r.action = ACT_ALLOC;
    r.request_size = sz;
    r.block_address = $urandom;
    send_item(r);
    if (sb.pending.size() > 0 && sb.pending[$].status == ST_OK)
      live_addrs.push_back(sb.pending[$].granted_address);
  endtask

  task automatic free_at(input logic [31:0] a);
    req_t r;
    r = '0;
    r.action = ACT_FREE;
    r.block_address = a;
    r.request_size = $urandom;
    send_item(r);
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (sb.pending.size() > 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (450) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_POOL_SIZE) sb.pool = val;
    else sb.align_lg = val[4:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int n, input logic [31:0] pmax);
    int k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: alloc($urandom);
        1, 2, 3: begin
          if (live_addrs.size() > 0) begin
            k = $urandom_range(live_addrs.size() - 1);
            free_at(live_addrs[k]);
            live_addrs.delete(k);
          end else begin
            free_at($urandom);
          end
        end
        4: free_at($urandom);
        default: alloc($urandom_range(pmax >> 3));
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    start = 0;
    req = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 21;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero pool rejects every nonzero size; a zero size still fits at 0
    alloc(32'd0);
    alloc(32'hFFFF_FFFF);
    free_at(32'd0);
    drain();
    write_cfg(CFG_POOL_SIZE, 32'hFFFF_FFFF);
    write_cfg(CFG_ALIGN, 5'd31);
    alloc(32'd0);
    alloc(32'hFFFF_FFFF);
    alloc(32'hFFFF_0000);
    alloc(32'd1);
    alloc(32'd1);
    free_at(32'd0);
    free_at(32'd0);
    free_at(32'hFFFF_FFFF);
    drain();
    write_cfg(CFG_ALIGN, 5'd0);
    write_cfg(CFG_POOL_SIZE, 32'd100);
    for (int i = 0; i < 70; i++) alloc(32'd1);
    // shrink pool below live blocks
    drain();
    write_cfg(CFG_POOL_SIZE, 32'd10);
    for (int i = 0; i < 40; i++) free_at(live_addrs.pop_front());
    alloc(32'd5);
    alloc(32'd20);
    drain();

    write_cfg(CFG_POOL_SIZE, 32'd4096);
    write_cfg(CFG_ALIGN, 5'd4);
    random_phase(600, 32'd4096);
    drain();
    idle_pct = 52;
    write_cfg(CFG_ALIGN, 5'd16);
    write_cfg(CFG_POOL_SIZE, 32'h00FF_FFFF);
    random_phase(600, 32'h00FF_FFFF);
    drain();
    idle_pct = 0;
    write_cfg(CFG_ALIGN, 5'd2);
    write_cfg(CFG_POOL_SIZE, 32'h8000_0000);
    random_phase(300, 32'hFFFF_FFFF);
    drain();
    write_cfg(CFG_ALIGN, 5'd8);
    write_cfg(CFG_POOL_SIZE, 32'd2048);
    random_phase(250, 32'd2048);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
